>>> src/tdpt_pkg.sv
// shared widths, command/status bundles and divisor select codes
// for the trial division prime test; no dependencies
`default_nettype none

package tdpt_pkg;

   localparam int VALUE_WIDTH = 32;
   // divisor limit stays below sqrt(2^VALUE_WIDTH) plus one step of 6
   localparam int LIM_WIDTH   = VALUE_WIDTH / 2 + 4;
   localparam int SQ_WIDTH    = VALUE_WIDTH + 4;
   localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);

   typedef logic [VALUE_WIDTH-1:0] value_type;

   localparam logic [1:0] DSEL_THREE = 2'd0;
   localparam logic [1:0] DSEL_PLUS  = 2'd1;
   localparam logic [1:0] DSEL_MINUS = 2'd2;

   typedef struct packed {
      logic       load;
      logic       step;
      logic       div_start;
      logic [1:0] div_sel;
      logic       put;
      logic       put_bit;
   } cmd_type;

   typedef struct packed {
      logic le_one;
      logic lt_four;
      logic even;
      logic lt_nine;
      logic sq_le_n;
      logic div_done;
      logic rem_zero;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

>>> src/tdpt_req_if.sv
// request channel: candidate value with valid/ready
// depends on tdpt_pkg
`default_nettype none

interface tdpt_req_if;
   logic                valid;
   logic                ready;
   tdpt_pkg::value_type candidate_value;

   modport source (output valid, output candidate_value, input ready);
   modport sink   (input valid, input candidate_value, output ready);
endinterface

`default_nettype wire

>>> src/tdpt_rsp_if.sv
// response channel: prime flag with valid/ready
// no dependencies
`default_nettype none

interface tdpt_rsp_if;
   logic valid;
   logic ready;
   logic is_prime;

   modport source (output valid, output is_prime, input ready);
   modport sink   (input valid, input is_prime, output ready);
endinterface

`default_nettype wire

>>> src/trial_division_prime_test.sv
// top level of the trial division prime test: controller plus datapath
// depends on tdpt_pkg, tdpt_req_if, tdpt_rsp_if, tdpt_ctrl, tdpt_dp
//
//   channel    direction   payload
//   req_chan   in          candidate_value [VALUE_WIDTH-1:0]
//   rsp_chan   out         is_prime
//
// values below 9 and even values: decided without a division
// otherwise a divide by 3, then 6k-1/6k+1 divisor pairs, about
// sqrt(n)/6 pairs; divisions use the one-bit-per-cycle remainder unit
// synchronous reset clears control only; a new beat is taken while the
// previous result still waits in the output register

`default_nettype none

module trial_division_prime_test (
   input  wire        clock,
   input  wire        reset,
   tdpt_req_if.sink   req_chan,
   tdpt_rsp_if.source rsp_chan
);

   tdpt_pkg::cmd_type    cmd;
   tdpt_pkg::status_type status;
   logic                 req_ready;
   logic                 rsp_valid;
   logic                 is_prime;

   tdpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tdpt_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .candidate_value (req_chan.candidate_value),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_valid),
      .is_prime        (is_prime)
   );

   assign req_chan.ready    = req_ready;
   assign rsp_chan.valid    = rsp_valid;
   assign rsp_chan.is_prime = is_prime;

endmodule

`default_nettype wire

>>> src/tdpt_dp.sv
// datapath: candidate register, 6k limit and its square, bit-serial
// remainder unit and the result register; depends on tdpt_pkg
`default_nettype none

module tdpt_dp (
   input  wire                  clock,
   input  wire                  reset,
   input  tdpt_pkg::cmd_type    cmd,
   output tdpt_pkg::status_type status,
   input  tdpt_pkg::value_type  candidate_value,
   input  wire                  rsp_ready,
   output logic                 rsp_valid,
   output logic                 is_prime
);

   localparam int W  = tdpt_pkg::VALUE_WIDTH;
   localparam int LW = tdpt_pkg::LIM_WIDTH;
   localparam int SW = tdpt_pkg::SQ_WIDTH;
   localparam int CW = tdpt_pkg::CNT_WIDTH;

   logic [W-1:0]  n_ff, n_in;
   logic [LW-1:0] limit_ff, limit_in;
   logic [SW-1:0] sq_ff, sq_in;
   logic [SW-1:0] lim_ext;

   logic [W-1:0]  dvd_ff, dvd_in;
   logic [LW-1:0] dvs_ff, dvs_in;
   logic [LW-1:0] rem_ff, rem_in;
   logic [LW:0]   trial;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic          valid_ff, valid_in;
   logic          prime_ff, prime_in;

   assign lim_ext = SW'(limit_ff);
   assign trial   = {rem_ff, dvd_ff[W-1]};

   always_comb begin
      n_in     = n_ff;
      limit_in = limit_ff;
      sq_in    = sq_ff;
      if (cmd.load) begin
         n_in     = candidate_value;
         limit_in = '0;
         sq_in    = '0;
      end else if (cmd.step) begin
         // (l+6)^2 = l^2 + 12l + 36
         limit_in = limit_ff + LW'(6);
         sq_in    = sq_ff + (lim_ext << 3) + (lim_ext << 2) + SW'(36);
      end
   end

   always_comb begin
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (cmd.div_start) begin
         dvd_in  = n_ff;
         rem_in  = '0;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
         done_in = 1'b0;
         case (cmd.div_sel)
            tdpt_pkg::DSEL_THREE: dvs_in = LW'(3);
            tdpt_pkg::DSEL_PLUS:  dvs_in = limit_ff + LW'(1);
            tdpt_pkg::DSEL_MINUS: dvs_in = limit_ff - LW'(1);
            default:              dvs_in = LW'(3);
         endcase
      end else if (busy_ff) begin
         // one quotient bit per cycle, restoring form
         dvd_in = dvd_ff << 1;
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = LW'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[LW-1:0];
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      prime_in = prime_ff;
      if (cmd.put) begin
         valid_in = 1'b1;
         prime_in = cmd.put_bit;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      limit_ff <= limit_in;
      sq_ff    <= sq_in;
      dvd_ff   <= dvd_in;
      dvs_ff   <= dvs_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      prime_ff <= prime_in;
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      status.le_one   = (n_ff <= W'(1));
      status.lt_four  = (n_ff < W'(4));
      status.even     = ~n_ff[0];
      status.lt_nine  = (n_ff < W'(9));
      status.sq_le_n  = (sq_ff <= SW'(n_ff));
      status.div_done = done_ff;
      status.rem_zero = (rem_ff == '0);
      status.out_free = ~valid_ff | rsp_ready;
   end

   assign rsp_valid = valid_ff;
   assign is_prime  = prime_ff;

endmodule

`default_nettype wire

>>> src/tdpt_ctrl.sv
// controller: sequences small-value checks, the divide by 3 and the
// 6k-1 / 6k+1 divisor pairs; depends on tdpt_pkg
`default_nettype none

module tdpt_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  tdpt_pkg::status_type status,
   output tdpt_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_CLASSIFY = 3'd1;
   localparam logic [2:0] S_DIV3     = 3'd2;
   localparam logic [2:0] S_TEST     = 3'd3;
   localparam logic [2:0] S_LAUNCH   = 3'd4;
   localparam logic [2:0] S_DIVP     = 3'd5;
   localparam logic [2:0] S_DIVM     = 3'd6;
   localparam logic [2:0] S_FINISH   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       result_ff, result_in;

   always_comb begin
      state_in  = state_ff;
      result_in = result_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.div_sel = tdpt_pkg::DSEL_THREE;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CLASSIFY;
            end
         end
         S_CLASSIFY: begin
            state_in = S_FINISH;
            if (status.le_one) begin
               result_in = 1'b0;
            end else if (status.lt_four) begin
               result_in = 1'b1;
            end else if (status.even) begin
               result_in = 1'b0;
            end else if (status.lt_nine) begin
               result_in = 1'b1;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = tdpt_pkg::DSEL_THREE;
               state_in      = S_DIV3;
            end
         end
         S_DIV3: begin
            if (status.div_done) begin
               if (status.rem_zero) begin
                  result_in = 1'b0;
                  state_in  = S_FINISH;
               end else begin
                  state_in = S_TEST;
               end
            end
         end
         S_TEST: begin
            // previous limit squared still within the candidate
            if (status.sq_le_n) begin
               cmd.step = 1'b1;
               state_in = S_LAUNCH;
            end else begin
               result_in = 1'b1;
               state_in  = S_FINISH;
            end
         end
         S_LAUNCH: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = tdpt_pkg::DSEL_PLUS;
            state_in      = S_DIVP;
         end
         S_DIVP: begin
            if (status.div_done) begin
               if (status.rem_zero) begin
                  result_in = 1'b0;
                  state_in  = S_FINISH;
               end else begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = tdpt_pkg::DSEL_MINUS;
                  state_in      = S_DIVM;
               end
            end
         end
         S_DIVM: begin
            if (status.div_done) begin
               if (status.rem_zero) begin
                  result_in = 1'b0;
                  state_in  = S_FINISH;
               end else begin
                  state_in = S_TEST;
               end
            end
         end
         S_FINISH: begin
            cmd.put_bit = result_ff;
            if (status.out_free) begin
               cmd.put  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire
